// ===== rtl/core/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpr_pkg: shared types and constants for the reader progress rank block
// Widths of the reader and page tables, the sequencer state and the
// divider handshake.
// ----------------------------------------------------------------------------
package rpr_pkg;

	localparam int READER_COUNT = 1024;
	localparam int PAGE_COUNT   = 1024;
	localparam int RW           = 10;   // reader index width
	localparam int PW           = 10;   // page index width
	localparam int CW           = 11;   // histogram count width
	localparam int SW           = 17;   // share width
	localparam int QW           = 27;   // dividend width: count << 16
	localparam logic [SW-1:0] SHARE_ONE = 17'h10000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_LOOK,
		ST_LOOK_WAIT,
		ST_HIST_RD,
		ST_HIST_WAIT,
		ST_HIST_WR,
		ST_SUM,
		ST_DIV,
		ST_DIV_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic          start;
		logic [QW-1:0] dividend;
		logic [PW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic          done;
		logic [SW-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/reader_progress_rank.sv =====
// ----------------------------------------------------------------------------
// reader_progress_rank: per-reader page tracking with percentile-rank queries
// Sequencer over the reader and histogram RAMs with a serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries mode, reader_id and
//   page_number. mode 0 moves a reader to a page and gives no result;
//   mode 1 queries and gives one result on the output channel
//   (out_valid / out_stall): share_q16, readers_below, other_readers,
//   reader_known.
//   One request at a time; in_stall is high while a request is at work.
//   A move takes a reader lookup, then a histogram read-modify-write
//   twice. A query walks the histogram one page a cycle, set by the
//   single histogram RAM port, then runs the one-bit-a-cycle divider.
//   Unknown or sole readers answer straight after the reader lookup.
//   After reset the block clears the histogram RAM and the reader RAM with
//   its valid bits, one entry a cycle, with in_stall high.
//   The result register holds while out_stall is high; the next request
//   is taken once it is delivered.
// ----------------------------------------------------------------------------
module reader_progress_rank (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     mode,
	input  logic [rpr_pkg::RW-1:0]   reader_id,
	input  logic [rpr_pkg::PW-1:0]   page_number,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [rpr_pkg::SW-1:0]   share_q16,
	output logic [rpr_pkg::CW-1:0]   readers_below,
	output logic [rpr_pkg::PW-1:0]   other_readers,
	output logic                     reader_known
);

	localparam int RW = rpr_pkg::RW;
	localparam int PW = rpr_pkg::PW;
	localparam int CW = rpr_pkg::CW;

	rpr_pkg::state_t state_q, state_d;

	logic          mode_q;
	logic [RW-1:0] who_q;
	logic [PW-1:0] page_q;      // new page for moves
	logic [PW-1:0] old_q;       // reader's page
	logic          was_known_q;
	logic          second_q;    // move: second histogram update (increment)
	logic [PW:0]   ptr_q;       // clear / walk pointer
	logic [CW-1:0] sum_q;
	logic [CW-1:0] total_q;
	logic          sum_vld_q;   // rdata of previous address pending add

	// RAM ports; reader RAM holds {valid, page}
	logic          pg_we;
	logic [RW-1:0] pg_addr;
	logic [PW:0]   pg_wdata, pg_rdata;
	logic          hs_we;
	logic [PW-1:0] hs_addr;
	logic [CW-1:0] hs_wdata, hs_rdata;

	rpr_pkg::div_req_t div_req;
	rpr_pkg::div_rsp_t div_rsp;

	rpr_ram #(.WIDTH(PW + 1), .DEPTH(rpr_pkg::READER_COUNT)) u_page_ram (
		.clk(clk), .we(pg_we), .addr(pg_addr), .wdata(pg_wdata), .rdata(pg_rdata)
	);

	rpr_ram #(.WIDTH(CW), .DEPTH(rpr_pkg::PAGE_COUNT)) u_hist_ram (
		.clk(clk), .we(hs_we), .addr(hs_addr), .wdata(hs_wdata), .rdata(hs_rdata)
	);

	rpr_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic accept;
	assign accept = in_valid && !in_stall;

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		pg_we    = 1'b0;
		pg_addr  = who_q;
		pg_wdata = {1'b1, page_q};
		hs_we    = 1'b0;
		hs_addr  = second_q ? page_q : old_q;
		hs_wdata = second_q ? hs_rdata + 1'b1 :
			(hs_rdata != '0 ? hs_rdata - 1'b1 : hs_rdata);
		div_req.start    = 1'b0;
		div_req.dividend = {sum_q, 16'h0};
		div_req.divisor  = PW'(total_q - 1'b1);
		unique case (state_q)
			rpr_pkg::ST_CLEAR: begin
				hs_we    = 1'b1;
				hs_addr  = ptr_q[PW-1:0];
				hs_wdata = '0;
				pg_we    = 1'b1;
				pg_addr  = ptr_q[RW-1:0];
				pg_wdata = '0;
				if (ptr_q[PW-1:0] == '1) begin
					state_d = rpr_pkg::ST_IDLE;
				end
			end
			rpr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = rpr_pkg::ST_LOOK;
				end
			end
			rpr_pkg::ST_LOOK: begin
				state_d = rpr_pkg::ST_LOOK_WAIT;
			end
			rpr_pkg::ST_LOOK_WAIT: begin
				if (mode_q) begin
					if (!pg_rdata[PW] || total_q <= CW'(1)) begin
						state_d = rpr_pkg::ST_OUT;
					end else begin
						state_d = rpr_pkg::ST_SUM;
					end
				end else begin
					state_d = rpr_pkg::ST_HIST_RD;
				end
			end
			rpr_pkg::ST_HIST_RD: begin
				state_d = rpr_pkg::ST_HIST_WAIT;
			end
			rpr_pkg::ST_HIST_WAIT: begin
				state_d = rpr_pkg::ST_HIST_WR;
			end
			rpr_pkg::ST_HIST_WR: begin
				// skip the decrement when the reader was not known
				hs_we = second_q || was_known_q;
				if (second_q) begin
					pg_we   = 1'b1;
					state_d = rpr_pkg::ST_IDLE;
				end else begin
					state_d = rpr_pkg::ST_HIST_RD;
				end
			end
			rpr_pkg::ST_SUM: begin
				hs_addr = ptr_q[PW-1:0];
				if (ptr_q >= {1'b0, old_q}) begin
					if (!sum_vld_q) begin
						state_d = rpr_pkg::ST_DIV;
					end
				end
			end
			rpr_pkg::ST_DIV: begin
				div_req.start = 1'b1;
				state_d       = rpr_pkg::ST_DIV_WAIT;
			end
			rpr_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					state_d = rpr_pkg::ST_OUT;
				end
			end
			rpr_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = rpr_pkg::ST_IDLE;
				end
			end
			default: state_d = rpr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= rpr_pkg::ST_CLEAR;
			total_q   <= '0;
			ptr_q     <= '0;
			second_q  <= 1'b0;
			sum_vld_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				rpr_pkg::ST_CLEAR: begin
					ptr_q <= ptr_q + 1'b1;
				end
				rpr_pkg::ST_IDLE: begin
					ptr_q     <= '0;
					second_q  <= 1'b0;
					sum_vld_q <= 1'b0;
				end
				rpr_pkg::ST_LOOK_WAIT: begin
					if (!mode_q && !pg_rdata[PW]) begin
						total_q <= total_q + 1'b1;
					end
				end
				rpr_pkg::ST_HIST_WR: begin
					second_q <= 1'b1;
				end
				rpr_pkg::ST_SUM: begin
					// advance one page a cycle; add data read last cycle
					sum_vld_q <= (ptr_q < {1'b0, old_q});
					if (ptr_q < {1'b0, old_q}) begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				rpr_pkg::ST_DIV_WAIT: begin
					if (div_rsp.done) begin
						out_valid <= 1'b1;
					end
				end
				rpr_pkg::ST_OUT: begin
					if (state_d == rpr_pkg::ST_IDLE) begin
						out_valid <= 1'b0;
					end else begin
						out_valid <= 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == rpr_pkg::ST_LOOK_WAIT && state_d == rpr_pkg::ST_OUT) begin
				out_valid <= 1'b1;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			who_q  <= reader_id;
			page_q <= page_number;
			sum_q  <= '0;
		end
		if (state_q == rpr_pkg::ST_LOOK_WAIT) begin
			old_q         <= pg_rdata[PW-1:0];
			was_known_q   <= pg_rdata[PW];
			share_q16     <= (mode_q && pg_rdata[PW] && total_q <= CW'(1)) ?
				rpr_pkg::SHARE_ONE : '0;
			readers_below <= '0;
			other_readers <= '0;
			reader_known  <= mode_q && pg_rdata[PW];
		end
		if (state_q == rpr_pkg::ST_SUM && sum_vld_q) begin
			sum_q <= sum_q + hs_rdata;
		end
		if (state_q == rpr_pkg::ST_DIV_WAIT && div_rsp.done) begin
			share_q16     <= div_rsp.quotient;
			readers_below <= sum_q;
			other_readers <= PW'(total_q - 1'b1);
		end
	end

endmodule

// ===== rtl/core/rpr_ram.sv =====
// ----------------------------------------------------------------------------
// rpr_ram: generic single-port RAM
// One address a cycle: writes when we is high, reads every cycle, read data registered.
// ----------------------------------------------------------------------------
module rpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== rtl/core/rpr_div.sv =====
// ----------------------------------------------------------------------------
// rpr_div: radix-2 restoring divider
// One quotient bit a cycle over the dividend width.
// ----------------------------------------------------------------------------
module rpr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  rpr_pkg::div_req_t  req,
	output rpr_pkg::div_rsp_t  rsp
);

	localparam int QW = rpr_pkg::QW;
	localparam int PW = rpr_pkg::PW;
	localparam int SW = rpr_pkg::SW;

	logic [QW-1:0]         quo_q;
	logic [PW-1:0]         rem_q;
	logic [PW-1:0]         dvs_q;
	logic [$clog2(QW)-1:0] cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [PW+1:0]         trial;
	logic [PW:0]           shifted;

	// remainder stays below the divisor, so it fits the divisor width
	always_comb begin
		shifted = {rem_q, quo_q[QW-1]};
		trial   = {1'b0, shifted} - {2'b00, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(QW))'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[PW+1]) begin
				rem_q <= trial[PW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[PW-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q[SW-1:0];

endmodule

// ===== dv/rpr_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpr_checker: tracks reader pages and checks every rank query result
// Mirrors the reader table and page histogram from accepted move requests,
// predicts each query response and compares it field by field, in order.
// ----------------------------------------------------------------------------
module rpr_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     mode,
	input  logic [rpr_pkg::RW-1:0]   reader_id,
	input  logic [rpr_pkg::PW-1:0]   page_number,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [rpr_pkg::SW-1:0]   share_q16,
	input  logic [rpr_pkg::CW-1:0]   readers_below,
	input  logic [rpr_pkg::PW-1:0]   other_readers,
	input  logic                     reader_known,
	output int                       fail_count,
	output int                       pending_count,
	output int                       query_count
);

	typedef struct packed {
		logic [rpr_pkg::SW-1:0] share;
		logic [rpr_pkg::CW-1:0] below;
		logic [rpr_pkg::PW-1:0] other;
		logic                   known;
	} rank_t;

	logic [rpr_pkg::PW-1:0] page_of [rpr_pkg::READER_COUNT];
	logic                   is_known [rpr_pkg::READER_COUNT];
	int                     readers_on [rpr_pkg::PAGE_COUNT];
	int                     known_total;
	rank_t                  rank_queue[$];

	function automatic rank_t rank_of(input logic [rpr_pkg::RW-1:0] who);
		rank_t r;
		int    sum;
		r = '0;
		sum = 0;
		if (is_known[who]) begin
			r.known = 1'b1;
			if (known_total <= 1) begin
				r.share = rpr_pkg::SHARE_ONE;
			end else begin
				for (int p = 0; p < page_of[who]; p++)
					sum += readers_on[p];
				r.below = rpr_pkg::CW'(sum);
				r.other = rpr_pkg::PW'(known_total - 1);
				r.share = rpr_pkg::SW'((longint'(sum) << 16) / (known_total - 1));
			end
		end
		return r;
	endfunction

	assign pending_count = rank_queue.size();

	always @(posedge clk or negedge arst_n) begin
		rank_t got;
		rank_t want;
		if (!arst_n) begin
			for (int i = 0; i < rpr_pkg::READER_COUNT; i++) begin
				is_known[i] = 1'b0;
				page_of[i] = '0;
			end
			for (int i = 0; i < rpr_pkg::PAGE_COUNT; i++)
				readers_on[i] = 0;
			known_total = 0;
			rank_queue.delete();
			fail_count = 0;
			query_count = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{share_q16, readers_below, other_readers, reader_known};
				if (rank_queue.size() == 0) begin
					$error("unexpected response share_q16=%0d", share_q16);
					fail_count++;
				end else begin
					want = rank_queue.pop_front();
					query_count++;
					if (got.share !== want.share) begin
						$error("share_q16 exp %0d got %0d", want.share, got.share);
						fail_count++;
					end
					if (got.below !== want.below) begin
						$error("readers_below exp %0d got %0d", want.below, got.below);
						fail_count++;
					end
					if (got.other !== want.other) begin
						$error("other_readers exp %0d got %0d", want.other, got.other);
						fail_count++;
					end
					if (got.known !== want.known) begin
						$error("reader_known exp %0d got %0d", want.known, got.known);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (mode) begin
					rank_queue.push_back(rank_of(reader_id));
				end else begin
					if (is_known[reader_id]) begin
						if (readers_on[page_of[reader_id]] > 0)
							readers_on[page_of[reader_id]]--;
					end else begin
						is_known[reader_id] = 1'b1;
						known_total++;
					end
					page_of[reader_id] = page_number;
					readers_on[page_number]++;
				end
			end
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the reader progress rank block
// Directed corner requests, then random move/query traffic with random
// gaps and response back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WATCHDOG_LIMIT = 20000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic                   mode = 1'b0;
	logic [rpr_pkg::RW-1:0] reader_id = '0;
	logic [rpr_pkg::PW-1:0] page_number = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [rpr_pkg::SW-1:0] share_q16;
	logic [rpr_pkg::CW-1:0] readers_below;
	logic [rpr_pkg::PW-1:0] other_readers;
	logic                   reader_known;
	int                     fail_count;
	int                     pending_count;
	int                     query_count;
	int                     move_count = 0;
	int                     idle_cycles = 0;
	bit                     hold_off = 1'b0;
	bit                     stim_done = 1'b0;
	logic [rpr_pkg::RW-1:0] seen_readers[$];

	always #5 clk = ~clk;

	reader_progress_rank dut (.*);

	rpr_checker checker_i (.*);

	function automatic int gap_len();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 8) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// offer one request and hold it until accepted; returns at a falling edge
	task automatic send_request(input logic m, input logic [rpr_pkg::RW-1:0] who,
		input logic [rpr_pkg::PW-1:0] pg);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		reader_id <= who;
		page_number <= pg;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (!m) begin
			move_count++;
			seen_readers.push_back(who);
		end
		@(negedge clk);
	endtask

	function automatic logic [rpr_pkg::RW-1:0] pick_reader();
		if (seen_readers.size() > 0 && $urandom_range(9) < 7)
			return seen_readers[$urandom_range(seen_readers.size() - 1)];
		return rpr_pkg::RW'($urandom_range(63));
	endfunction

	// receiver back-pressure, with one long hold-off
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (stim_done || $urandom_range(9) < 6) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b1;
				repeat (gap_len()) @(negedge clk);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		int tail;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: unknown, sole reader, extremes, same page, ties
		send_request(1'b1, 10'd0, 10'd0);
		send_request(1'b0, 10'd1023, 10'd1023);
		send_request(1'b1, 10'd1023, 10'd0);
		send_request(1'b0, 10'd0, 10'd0);
		send_request(1'b1, 10'd0, 10'd0);
		send_request(1'b1, 10'd1023, 10'd512);
		send_request(1'b0, 10'd1023, 10'd1023);
		send_request(1'b1, 10'd1023, 10'd0);
		send_request(1'b0, 10'd5, 10'd1023);
		send_request(1'b0, 10'd6, 10'h2AA);
		send_request(1'b0, 10'd7, 10'h155);
		send_request(1'b1, 10'd5, 10'd0);
		send_request(1'b1, 10'd1023, 10'd0);
		send_request(1'b1, 10'd0, 10'd0);
		send_request(1'b0, 10'd1023, 10'd0);
		send_request(1'b1, 10'd7, 10'd0);
		send_request(1'b1, 10'd512, 10'd0);

		// hold off the receiver so queries back up into the input
		hold_off = 1'b1;
		fork
			begin
				send_request(1'b1, 10'd5, 10'd0);
				send_request(1'b1, 10'd6, 10'd0);
				send_request(1'b0, 10'd8, 10'd3);
			end
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
		join

		// random: mostly moves among a modest reader set, low pages mostly
		for (int n = 0; n < 520; n++) begin
			if ($urandom_range(9) < 6)
				send_request(1'b0,
					$urandom_range(9) == 0 ? rpr_pkg::RW'($urandom) : pick_reader(),
					$urandom_range(9) == 0 ? rpr_pkg::PW'($urandom) :
					rpr_pkg::PW'($urandom_range(127)));
			else
				send_request(1'b1, pick_reader(), rpr_pkg::PW'($urandom));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		tail = 0;
		while (pending_count > 0 && tail < 50000) begin
			@(posedge clk);
			tail++;
		end
		repeat (1200) @(posedge clk);
		$display("Covered %0d moves and %0d checked queries.", move_count, query_count);
		if (fail_count == 0 && pending_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/rpr_pkg.sv
rtl/core/rpr_ram.sv
rtl/core/rpr_div.sv
rtl/core/reader_progress_rank.sv
dv/rpr_checker.sv
dv/testbench.sv
